// File: hw/rtl/agm_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and the balance gain table of the audio mixer.
package agm_pkg;

  localparam int NUM_CH     = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int GAIN_W     = 16;
  localparam int CNT_W      = 4;
  localparam int BAL_W      = 9;
  localparam int APB_DW     = 32;

  localparam logic [GAIN_W-1:0] VOL_RESET   = 16'd8192;
  localparam logic              MONO_RESET  = 1'b0;
  localparam logic [BAL_W-1:0]  BAL_RESET   = 9'd128;
  localparam logic [CNT_W-1:0]  CNT_RESET   = 4'd2;
  localparam logic [BAL_W-1:0]  BAL_CENTRE  = 9'd128;
  localparam logic [BAL_W-1:0]  BAL_FULL    = 9'd256;
  localparam logic [GAIN_W-1:0] GAIN_UNITY  = 16'd32768;

  // pi/512 in Q3.61
  localparam logic [63:0] PI_STEP_Q61 = 64'd14148475504056881;

  typedef enum logic [1:0] {
    REG_VOLUME  = 2'd0,
    REG_MONO    = 2'd1,
    REG_BALANCE = 2'd2,
    REG_COUNT   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]  n;        // active channels, 1..MAX_CHANNELS
    logic              mono_on;
    logic              bal_on;
    logic [GAIN_W-1:0] vol;
    logic [GAIN_W-1:0] g0;       // Q1.15 gain, channel 0
    logic [GAIN_W-1:0] g1;       // Q1.15 gain, channel 1
  } cfg_t;

  typedef logic [GAIN_W-1:0] sin_rom_t [256];

  // (a * b) >> 61, elaboration only
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // round(32768 * sin(k*pi/512)) by Taylor series, elaboration only
  function automatic logic [GAIN_W-1:0] sin_q15(input int k);
    logic [63:0] x, x2, term, pos, neg, s, r;
    x    = 64'(k) * PI_STEP_Q61;
    x2   = mul_q61(x, x);
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 1; n <= 12; n++) begin
      term = mul_q61(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = pos - neg;
    r = (s + (64'd1 << 45)) >> 46;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return r[GAIN_W-1:0];
  endfunction

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t t;
    for (int k = 0; k < 256; k++) begin
      t[k] = sin_q15(k);
    end
    return t;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  // gain for k in 0..256; the top entry is exact unity
  function automatic logic [GAIN_W-1:0] sin_gain(input logic [BAL_W-1:0] k);
    return k[BAL_W-1] ? GAIN_UNITY : SIN_ROM[k[BAL_W-2:0]];
  endfunction

endpackage

// File: hw/rtl/agm_if.sv
`timescale 1ns / 1ps
// Frame channels of the audio mixer: input frame and mixed frame.
interface agm_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_ch0;
  logic [SAMPLE_BITS-1:0] sample_ch1;
  logic [SAMPLE_BITS-1:0] sample_ch2;
  logic [SAMPLE_BITS-1:0] sample_ch3;
  logic [SAMPLE_BITS-1:0] sample_ch4;
  logic [SAMPLE_BITS-1:0] sample_ch5;
  logic [SAMPLE_BITS-1:0] sample_ch6;
  logic [SAMPLE_BITS-1:0] sample_ch7;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7,
    output ready
  );
endinterface

interface agm_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] mixed_ch0;
  logic [SAMPLE_BITS-1:0] mixed_ch1;
  logic [SAMPLE_BITS-1:0] mixed_ch2;
  logic [SAMPLE_BITS-1:0] mixed_ch3;
  logic [SAMPLE_BITS-1:0] mixed_ch4;
  logic [SAMPLE_BITS-1:0] mixed_ch5;
  logic [SAMPLE_BITS-1:0] mixed_ch6;
  logic [SAMPLE_BITS-1:0] mixed_ch7;
  logic                   clipped;

  modport source (
    output valid, mixed_ch0, mixed_ch1, mixed_ch2, mixed_ch3,
           mixed_ch4, mixed_ch5, mixed_ch6, mixed_ch7, clipped,
    input  ready
  );
  modport sink (
    input  valid, mixed_ch0, mixed_ch1, mixed_ch2, mixed_ch3,
           mixed_ch4, mixed_ch5, mixed_ch6, mixed_ch7, clipped,
    output ready
  );
endinterface

// File: hw/rtl/agm_lane.sv
`timescale 1ns / 1ps
// One channel lane: volume multiply, then round to the working width.
module agm_lane #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic [1:0]                        en_i,
  input  logic                              active_i,
  input  logic [agm_pkg::GAIN_W-1:0]        vol_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic signed [SAMPLE_BITS+3:0]     level_o
);

  localparam int PW       = SAMPLE_BITS + agm_pkg::GAIN_W + 1;
  localparam int VW       = SAMPLE_BITS + 4;
  localparam int VOL_FRAC = 13;
  localparam logic [PW-1:0] VOL_HALF = PW'(2 ** (VOL_FRAC - 1));

  logic signed [PW-1:0] prod_d, prod_q, rnd;
  logic signed [VW-1:0] level_d, level_q;

  assign prod_d  = sample_i * $signed({1'b0, vol_i});
  assign rnd     = prod_q + $signed(VOL_HALF);
  // floor((p + 2^12) / 2^13); inactive channels carry zero
  assign level_d = active_i ? rnd[VOL_FRAC +: VW] : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

// File: hw/rtl/agm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider by a channel count of 1..8, eight quotient bits per stage.
module agm_div #(
  parameter int W      = 31,
  parameter int STAGES = 4
) (
  input  logic                         clk_i,
  input  logic [STAGES-1:0]            en_i,
  input  logic [agm_pkg::CNT_W-1:0]    divisor_i,
  input  logic [W-1:0]                 dividend_i,
  output logic [W-1:0]                 quot_o
);

  localparam int STEP = 8;
  localparam int PW   = STAGES * STEP;

  // num holds the dividend bits still to go on top, quotient bits shift in below
  logic [PW-1:0] num_q [STAGES];
  logic [2:0]    rem_q [STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_stg
    logic [PW-1:0] num_in, num_d;
    logic [2:0]    rem_in, rem_d;

    if (s == 0) begin : g_first
      assign num_in = PW'(dividend_i);
      assign rem_in = '0;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
    end

    always_comb begin
      logic [PW-1:0] num;
      logic [3:0]    r;
      num = num_in;
      r   = {1'b0, rem_in};
      for (int b = 0; b < STEP; b++) begin
        r   = {r[2:0], num[PW-1]};
        num = {num[PW-2:0], 1'b0};
        if (r >= divisor_i) begin
          r      = r - divisor_i;
          num[0] = 1'b1;
        end
      end
      num_d = num;
      rem_d = r[2:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        num_q[s] <= num_d;
      end
    end

    if (s < STAGES - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[s] <= rem_d;
        end
      end
    end
  end

  assign quot_o = num_q[STAGES-1][W-1:0];

endmodule

// File: hw/rtl/agm_merge.sv
`timescale 1ns / 1ps
// Merge stage: sums the lanes, averages them and applies mono to every active lane.
module agm_merge #(
  parameter int SAMPLE_BITS = 24,
  parameter int DIV_STAGES  = 4
) (
  input  logic                          clk_i,
  input  logic [DIV_STAGES+4:0]         en_i,
  input  agm_pkg::cfg_t                 cfg_i,
  input  logic signed [SAMPLE_BITS+3:0] level_i [agm_pkg::NUM_CH],
  output logic signed [SAMPLE_BITS+3:0] mix_o   [agm_pkg::NUM_CH]
);

  localparam int VW     = SAMPLE_BITS + 4;
  localparam int SW     = VW + 3;
  localparam int NCH    = agm_pkg::NUM_CH;
  localparam int ST_ABS = 3;
  localparam int ST_DIV = 4;
  localparam int ST_MIX = DIV_STAGES + 4;
  localparam int NLANE  = DIV_STAGES + 4;

  logic signed [VW-1:0] lane_q [NLANE][NCH];
  logic signed [VW:0]   sum1_q [NCH/2];
  logic signed [VW+1:0] sum2_q [NCH/4];
  logic signed [SW-1:0] sum3_q;
  logic [SW-1:0]        mag_q, quot;
  logic                 neg_q;
  logic [DIV_STAGES-1:0] negp_q;
  logic signed [SW-1:0] avg_full;
  logic signed [VW-1:0] avg;
  logic signed [VW-1:0] mix_d [NCH];
  logic signed [VW-1:0] mix_q [NCH];

  // lanes ride alongside the reduction
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lane_q[0] <= level_i;
    end
    for (int k = 1; k < NLANE; k++) begin
      if (en_i[k]) begin
        lane_q[k] <= lane_q[k-1];
      end
    end
  end

  // three-level registered adder tree
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < NCH / 2; i++) begin
        sum1_q[i] <= (VW+1)'(level_i[2*i]) + (VW+1)'(level_i[2*i+1]);
      end
    end
    if (en_i[1]) begin
      for (int i = 0; i < NCH / 4; i++) begin
        sum2_q[i] <= (VW+2)'(sum1_q[2*i]) + (VW+2)'(sum1_q[2*i+1]);
      end
    end
    if (en_i[2]) begin
      sum3_q <= SW'(sum2_q[0]) + SW'(sum2_q[1]);
    end
    if (en_i[ST_ABS]) begin
      neg_q <= sum3_q[SW-1];
      mag_q <= sum3_q[SW-1] ? SW'(-sum3_q) : SW'(sum3_q);
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en_i[ST_DIV+j]) begin
        negp_q[j] <= (j == 0) ? neg_q : negp_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  agm_div #(
    .W      (SW),
    .STAGES (DIV_STAGES)
  ) u_div (
    .clk_i      (clk_i),
    .en_i       (en_i[ST_DIV +: DIV_STAGES]),
    .divisor_i  (cfg_i.n),
    .dividend_i (mag_q),
    .quot_o     (quot)
  );

  // division of the magnitude rounds toward zero, sign restored after
  assign avg_full = negp_q[DIV_STAGES-1] ? -$signed(quot) : $signed(quot);
  assign avg      = avg_full[VW-1:0];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (cfg_i.mono_on && (agm_pkg::CNT_W'(c) < cfg_i.n)) begin
        mix_d[c] = avg;
      end else begin
        mix_d[c] = lane_q[NLANE-1][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_MIX]) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

// File: hw/rtl/agm_out.sv
`timescale 1ns / 1ps
// Output stage: constant-power balance on channels 0 and 1, saturation and clip flag.
module agm_out #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic [1:0]                    en_i,
  input  agm_pkg::cfg_t                 cfg_i,
  input  logic signed [SAMPLE_BITS+3:0] mix_i   [agm_pkg::NUM_CH],
  output logic [SAMPLE_BITS-1:0]        mixed_o [agm_pkg::NUM_CH],
  output logic                          clip_o
);

  localparam int VW       = SAMPLE_BITS + 4;
  localparam int BPW      = VW + agm_pkg::GAIN_W + 1;
  localparam int BAL_FRAC = 15;
  localparam int XW       = VW + 2;
  localparam int NCH      = agm_pkg::NUM_CH;
  localparam logic [BPW-1:0] BAL_HALF = BPW'(2 ** (BAL_FRAC - 1));
  localparam logic signed [XW-1:0] SMAX =
    $signed({{(XW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [XW-1:0] SMIN = ~SMAX;

  logic signed [VW-1:0]  lane_q [NCH];
  logic signed [BPW-1:0] bprod_q [2];
  logic signed [BPW-1:0] brnd [2];
  logic [SAMPLE_BITS-1:0] sat_d [NCH];
  logic [NCH-1:0]         clip_d;
  logic [SAMPLE_BITS-1:0] mixed_q [NCH];
  logic                   clip_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lane_q     <= mix_i;
      bprod_q[0] <= mix_i[0] * $signed({1'b0, cfg_i.g0});
      bprod_q[1] <= mix_i[1] * $signed({1'b0, cfg_i.g1});
    end
  end

  assign brnd[0] = bprod_q[0] + $signed(BAL_HALF);
  assign brnd[1] = bprod_q[1] + $signed(BAL_HALF);

  always_comb begin
    logic signed [XW-1:0] val;
    for (int c = 0; c < NCH; c++) begin
      if (cfg_i.bal_on && c < 2) begin
        val = brnd[(c < 2) ? c : 0][BAL_FRAC +: XW];
      end else begin
        val = XW'(lane_q[c]);
      end
      clip_d[c] = 1'b0;
      if (val > SMAX) begin
        val       = SMAX;
        clip_d[c] = 1'b1;
      end else if (val < SMIN) begin
        val       = SMIN;
        clip_d[c] = 1'b1;
      end
      sat_d[c] = val[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mixed_q <= sat_d;
      clip_q  <= |clip_d;
    end
  end

  assign mixed_o = mixed_q;
  assign clip_o  = clip_q;

endmodule

// File: hw/rtl/audio_gain_mono_balance_mixer.sv
`timescale 1ns / 1ps
// Throughput: one frame per cycle while the output is not stalled.
// The mono divider retires 8 quotient bits per stage.
// Each stage holds while full and stalled, so bubbles close up under output back-pressure.
// Reset (rst_ni low, async): pipeline emptied, registers to volume 8192, mono off,
// balance 128, channel count 2. No clearing pass; a frame is accepted right after reset.
module audio_gain_mono_balance_mixer #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  agm_in_if.sink                            in_i,
  agm_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [agm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [agm_pkg::APB_DW-1:0]        pwdata,
  output logic [agm_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int VW         = SAMPLE_BITS + 4;
  localparam int SW         = VW + 3;
  localparam int DIV_STAGES = (SW + 7) / 8;
  localparam int NCH        = agm_pkg::NUM_CH;
  localparam int ST_MERGE   = 2;
  localparam int NS         = DIV_STAGES + 9;

  logic [agm_pkg::GAIN_W-1:0] vol_q;
  logic                       mono_q;
  logic [agm_pkg::BAL_W-1:0]  bal_q;
  logic [agm_pkg::CNT_W-1:0]  cnt_q;
  logic [agm_pkg::GAIN_W-1:0] g0_q, g1_q;
  logic [agm_pkg::CNT_W-1:0]  n_eff;
  logic [agm_pkg::BAL_W-1:0]  bal_eff;
  logic                       cfg_wr;
  agm_pkg::reg_idx_e          reg_idx;
  agm_pkg::cfg_t              cfg;

  logic [NS-1:0] vld_q, vld_d, en;

  logic signed [SAMPLE_BITS-1:0] smp   [NCH];
  logic signed [VW-1:0]          level [NCH];
  logic signed [VW-1:0]          mix   [NCH];
  logic [SAMPLE_BITS-1:0]        mixed [NCH];
  logic                          clip;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = agm_pkg::reg_idx_e'(paddr[agm_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q  <= agm_pkg::VOL_RESET;
      mono_q <= agm_pkg::MONO_RESET;
      bal_q  <= agm_pkg::BAL_RESET;
      cnt_q  <= agm_pkg::CNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        agm_pkg::REG_VOLUME:  vol_q  <= pwdata[agm_pkg::GAIN_W-1:0];
        agm_pkg::REG_MONO:    mono_q <= pwdata[0];
        agm_pkg::REG_BALANCE: bal_q  <= pwdata[agm_pkg::BAL_W-1:0];
        agm_pkg::REG_COUNT:   cnt_q  <= pwdata[agm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      agm_pkg::REG_VOLUME:  prdata = agm_pkg::APB_DW'(vol_q);
      agm_pkg::REG_MONO:    prdata = agm_pkg::APB_DW'(mono_q);
      agm_pkg::REG_BALANCE: prdata = agm_pkg::APB_DW'(bal_q);
      agm_pkg::REG_COUNT:   prdata = agm_pkg::APB_DW'(cnt_q);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    if (cnt_q == '0) begin
      n_eff = agm_pkg::CNT_W'(1);
    end else if (cnt_q > agm_pkg::CNT_W'(MAX_CHANNELS)) begin
      n_eff = agm_pkg::CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = cnt_q;
    end
    bal_eff = (bal_q > agm_pkg::BAL_FULL) ? agm_pkg::BAL_FULL : bal_q;
  end

  // gains follow the balance register; settled long before a word reaches them
  always_ff @(posedge clk_i) begin
    g0_q <= agm_pkg::sin_gain(agm_pkg::BAL_FULL - bal_eff);
    g1_q <= agm_pkg::sin_gain(bal_eff);
  end

  assign cfg.n       = n_eff;
  assign cfg.mono_on = mono_q && (n_eff > agm_pkg::CNT_W'(1));
  assign cfg.bal_on  = (bal_eff != agm_pkg::BAL_CENTRE) && (n_eff > agm_pkg::CNT_W'(1));
  assign cfg.vol     = vol_q;
  assign cfg.g0      = g0_q;
  assign cfg.g1      = g1_q;

  // ---------------- pipeline control ----------------
  // a stage moves when the output drains or some stage at or after it is empty
  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = out_o.ready || !(&vld_q[NS-1:i]);
  end

  assign vld_d = {vld_q[NS-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = vld_q[NS-1];

  // ---------------- datapath ----------------
  assign smp[0] = in_i.sample_ch0;
  assign smp[1] = in_i.sample_ch1;
  assign smp[2] = in_i.sample_ch2;
  assign smp[3] = in_i.sample_ch3;
  assign smp[4] = in_i.sample_ch4;
  assign smp[5] = in_i.sample_ch5;
  assign smp[6] = in_i.sample_ch6;
  assign smp[7] = in_i.sample_ch7;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_on
      agm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk_i    (clk_i),
        .en_i     (en[1:0]),
        .active_i (agm_pkg::CNT_W'(c) < cfg.n),
        .vol_i    (cfg.vol),
        .sample_i (smp[c]),
        .level_o  (level[c])
      );
    end else begin : g_off
      assign level[c] = '0;
    end
  end

  agm_merge #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DIV_STAGES  (DIV_STAGES)
  ) u_merge (
    .clk_i   (clk_i),
    .en_i    (en[ST_MERGE +: DIV_STAGES+5]),
    .cfg_i   (cfg),
    .level_i (level),
    .mix_o   (mix)
  );

  agm_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk_i   (clk_i),
    .en_i    (en[NS-2 +: 2]),
    .cfg_i   (cfg),
    .mix_i   (mix),
    .mixed_o (mixed),
    .clip_o  (clip)
  );

  assign out_o.mixed_ch0 = mixed[0];
  assign out_o.mixed_ch1 = mixed[1];
  assign out_o.mixed_ch2 = mixed[2];
  assign out_o.mixed_ch3 = mixed[3];
  assign out_o.mixed_ch4 = mixed[4];
  assign out_o.mixed_ch5 = mixed[5];
  assign out_o.mixed_ch6 = mixed[6];
  assign out_o.mixed_ch7 = mixed[7];
  assign out_o.clipped   = clip;

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted word did not enter the first stage");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q) && !out_o.ready)
    else $error("input stalled while the pipeline had room");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |=> vld_q[0] && vld_q[NS-1])
    else $error("stalled pipeline lost a word");
`endif

endmodule

// File: bench/agm_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the audio mixer: shadows the registers, predicts every mixed word and checks it.
module agm_frame_checker
  import agm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  agm_in_if                     frame_in_i,
  agm_out_if                    frame_out_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]     pwdata,
  input  logic [APB_DW-1:0]     prdata,
  input  logic                  pready,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int     SB        = 24;
  localparam longint SMAX      = (longint'(1) << (SB - 1)) - 1;
  localparam longint SMIN      = -SMAX - 1;
  localparam real    PI        = 3.14159265358979323846;

  typedef logic [NUM_CH-1:0][SB-1:0] frame_t;
  typedef struct packed {
    logic   clipped;
    frame_t ch;
  } mix_frame_t;

  logic [GAIN_W-1:0] vol_q;
  logic              mono_q;
  logic [BAL_W-1:0]  bal_q;
  logic [CNT_W-1:0]  cnt_q;

  int         pan_gain [0:256];
  mix_frame_t mix_expect_q [$];

  // constant-power gains, Q1.15 rounded
  initial begin
    for (int k = 0; k <= 256; k++) begin
      pan_gain[k] = $rtoi(32768.0 * $sin(k * PI / 512.0) + 0.5);
      if (pan_gain[k] > 32768) begin
        pan_gain[k] = 32768;
      end
    end
  end

  function automatic longint round_shr(input longint x, input int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic mix_frame_t mix_predict(input frame_t smp);
    longint     lvl [NUM_CH];
    longint     acc;
    int         n;
    int         b;
    mix_frame_t r;
    n = int'(cnt_q);
    if (n < 1) n = 1;
    if (n > NUM_CH) n = NUM_CH;
    b = int'(bal_q);
    if (b > 256) b = 256;
    for (int c = 0; c < NUM_CH; c++) begin
      lvl[c] = (c < n) ? round_shr(longint'(signed'(smp[c])) * longint'(vol_q), 13) : 0;
    end
    if (mono_q && n > 1) begin
      acc = 0;
      for (int c = 0; c < n; c++) acc += lvl[c];
      acc = acc / longint'(n);  // truncates toward zero
      for (int c = 0; c < n; c++) lvl[c] = acc;
    end
    // centre is a plain bypass, no 0.707 pair
    if (b != 128 && n > 1) begin
      lvl[0] = round_shr(lvl[0] * longint'(pan_gain[256 - b]), 15);
      lvl[1] = round_shr(lvl[1] * longint'(pan_gain[b]), 15);
    end
    r.clipped = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      acc = 0;
      if (c < n) begin
        acc = lvl[c];
        if (acc > SMAX) begin
          acc       = SMAX;
          r.clipped = 1'b1;
        end
        if (acc < SMIN) begin
          acc       = SMIN;
          r.clipped = 1'b1;
        end
      end
      r.ch[c] = acc[SB-1:0];
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: %s expected %h got %h", $time, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t            smp;
    mix_frame_t        got;
    mix_frame_t        want;
    logic [APB_DW-1:0] rd_want;
    if (!rst_ni) begin
      vol_q        <= VOL_RESET;
      mono_q       <= MONO_RESET;
      bal_q        <= BAL_RESET;
      cnt_q        <= CNT_RESET;
      mix_expect_q.delete();
      pending_o    <= 0;
      fail_count_o = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[3:2]))
            REG_VOLUME:  vol_q  <= pwdata[GAIN_W-1:0];
            REG_MONO:    mono_q <= pwdata[0];
            REG_BALANCE: bal_q  <= pwdata[BAL_W-1:0];
            REG_COUNT:   cnt_q  <= pwdata[CNT_W-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_e'(paddr[3:2]))
            REG_VOLUME:  rd_want = APB_DW'(vol_q);
            REG_MONO:    rd_want = APB_DW'(mono_q);
            REG_BALANCE: rd_want = APB_DW'(bal_q);
            default:     rd_want = APB_DW'(cnt_q);
          endcase
          if (prdata !== rd_want) begin
            note_mismatch($sformatf("register read at %0h", paddr), rd_want, prdata);
          end
        end
      end

      if (frame_in_i.valid && frame_in_i.ready) begin
        smp = {frame_in_i.sample_ch7, frame_in_i.sample_ch6, frame_in_i.sample_ch5,
               frame_in_i.sample_ch4, frame_in_i.sample_ch3, frame_in_i.sample_ch2,
               frame_in_i.sample_ch1, frame_in_i.sample_ch0};
        mix_expect_q.push_back(mix_predict(smp));
      end

      if (frame_out_i.valid && frame_out_i.ready) begin
        got.clipped = frame_out_i.clipped;
        got.ch = {frame_out_i.mixed_ch7, frame_out_i.mixed_ch6, frame_out_i.mixed_ch5,
                  frame_out_i.mixed_ch4, frame_out_i.mixed_ch3, frame_out_i.mixed_ch2,
                  frame_out_i.mixed_ch1, frame_out_i.mixed_ch0};
        if (mix_expect_q.size() == 0) begin
          note_mismatch("mixed word with none outstanding, clipped", 32'hx, got.clipped);
        end else begin
          want = mix_expect_q.pop_front();
          for (int c = 0; c < NUM_CH; c++) begin
            if (got.ch[c] !== want.ch[c]) begin
              note_mismatch($sformatf("mixed_ch%0d", c), want.ch[c], got.ch[c]);
            end
          end
          if (got.clipped !== want.clipped) begin
            note_mismatch("clipped", want.clipped, got.clipped);
          end
        end
      end
      pending_o <= mix_expect_q.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top of the audio mixer bench: clock, reset, register writes, frame stimulus and verdict.
module tb;
  import agm_pkg::*;

  localparam int SB              = 24;
  localparam int PHASES          = 16;
  localparam int PHASE_FRAMES    = 88;
  localparam int DRAIN_CYCLES    = 32;
  localparam int NO_ACCEPT_LIMIT = 4000;

  typedef logic [NUM_CH-1:0][SB-1:0] frame_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  int                    src_idle_pct     = 0;
  int                    snk_stall_pct    = 0;
  int                    no_accept_cycles = 0;

  agm_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  agm_out_if #(.SAMPLE_BITS(SB)) out_if ();

  audio_gain_mono_balance_mixer #(
    .MAX_CHANNELS(8),
    .SAMPLE_BITS (SB)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  agm_frame_checker u_mix_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_in_i  (in_if),
    .frame_out_i (out_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver back-pressure
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      no_accept_cycles <= 0;
    end else if (no_accept_cycles >= NO_ACCEPT_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      no_accept_cycles <= no_accept_cycles + 1;
    end
  end

  // one APB transfer, ending with psel low so psel never drops and rises in one step
  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [APB_DW-1:0] data);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mix_cfg(input logic [15:0] vol, input logic mono, input logic [8:0] bal,
                             input logic [3:0] cnt);
    apb_xfer(1'b1, REG_VOLUME, APB_DW'(vol));
    apb_xfer(1'b1, REG_MONO, APB_DW'(mono));
    apb_xfer(1'b1, REG_BALANCE, APB_DW'(bal));
    apb_xfer(1'b1, REG_COUNT, APB_DW'(cnt));
    for (int i = 0; i < 4; i++) apb_xfer(1'b0, reg_idx_e'(i), '0);
  endtask

  task automatic send_frame(input frame_t f);
    logic rdy;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.sample_ch0 <= f[0];
    in_if.sample_ch1 <= f[1];
    in_if.sample_ch2 <= f[2];
    in_if.sample_ch3 <= f[3];
    in_if.sample_ch4 <= f[4];
    in_if.sample_ch5 <= f[5];
    in_if.sample_ch6 <= f[6];
    in_if.sample_ch7 <= f[7];
    // ready sampled mid-cycle, once everything has settled
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic frame_t pat_frame(input logic [SB-1:0] even_s, input logic [SB-1:0] odd_s);
    frame_t f;
    for (int c = 0; c < NUM_CH; c++) f[c] = c[0] ? odd_s : even_s;
    return f;
  endfunction

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return '0;
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int c = 0; c < NUM_CH; c++) f[c] = rand_sample();
    return f;
  endfunction

  initial begin : stim
    logic [15:0] vol;
    logic        mono;
    logic [8:0]  bal;
    logic [3:0]  cnt;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_if.valid      <= 1'b0;
    in_if.sample_ch0 <= '0;
    in_if.sample_ch1 <= '0;
    in_if.sample_ch2 <= '0;
    in_if.sample_ch3 <= '0;
    in_if.sample_ch4 <= '0;
    in_if.sample_ch5 <= '0;
    in_if.sample_ch6 <= '0;
    in_if.sample_ch7 <= '0;
    rst_ni           <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values read back
    for (int i = 0; i < 4; i++) apb_xfer(1'b0, reg_idx_e'(i), '0);

    // directed: unity, stereo, centre
    set_mix_cfg(16'd8192, 1'b0, 9'd128, 4'd2);
    send_frame(pat_frame(24'h7FFFFF, 24'h7FFFFF));
    send_frame(pat_frame(24'h800000, 24'h800000));
    send_frame(pat_frame(24'h000000, 24'h000000));
    send_frame(pat_frame(24'h7FFFFF, 24'h800000));
    wait_drained();
    // full volume, all eight channels, clipping both ways
    set_mix_cfg(16'hFFFF, 1'b0, 9'd128, 4'd8);
    send_frame(pat_frame(24'h7FFFFF, 24'h7FFFFF));
    send_frame(pat_frame(24'h800000, 24'h800000));
    send_frame(pat_frame(24'h555555, 24'h555555));
    send_frame(pat_frame(24'hAAAAAA, 24'hAAAAAA));
    wait_drained();
    // muted, mono, full left
    set_mix_cfg(16'd0, 1'b1, 9'd0, 4'd8);
    send_frame(pat_frame(24'h7FFFFF, 24'h800000));
    wait_drained();
    // mono, full right
    set_mix_cfg(16'd8192, 1'b1, 9'd256, 4'd8);
    send_frame(pat_frame(24'h7FFFFF, 24'h800000));
    send_frame(pat_frame(24'h7FFFFF, 24'h7FFFFF));
    wait_drained();
    // balance past full right is clamped
    set_mix_cfg(16'd12345, 1'b1, 9'd511, 4'd4);
    send_frame(pat_frame(24'h800000, 24'h7FFFFF));
    send_frame(rand_frame());
    wait_drained();
    // count zero acts as one channel: mono and balance skipped
    set_mix_cfg(16'hFFFF, 1'b1, 9'd0, 4'd0);
    send_frame(pat_frame(24'h7FFFFF, 24'h7FFFFF));
    send_frame(pat_frame(24'h800000, 24'h800000));
    wait_drained();
    // count above eight clamps to eight
    set_mix_cfg(16'd8192, 1'b0, 9'd64, 4'd15);
    send_frame(pat_frame(24'h7FFFFF, 24'h800000));
    send_frame(pat_frame(24'h800000, 24'h800000));
    wait_drained();
    // odd count, unused channels zero
    set_mix_cfg(16'd40000, 1'b1, 9'd200, 4'd3);
    send_frame(pat_frame(24'h7FFFFF, 24'h7FFFFF));
    send_frame(rand_frame());
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(4))
        0:       vol = 16'd0;
        1:       vol = 16'hFFFF;
        2:       vol = 16'd8192;
        default: vol = 16'($urandom_range(65535));
      endcase
      mono = 1'($urandom_range(1));
      case ($urandom_range(5))
        0:       bal = 9'd0;
        1:       bal = 9'd128;
        2:       bal = 9'd256;
        3:       bal = 9'($urandom_range(511, 257));
        default: bal = 9'($urandom_range(256));
      endcase
      cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
      set_mix_cfg(vol, mono, bal, cnt);

      case (p % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 82;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 82;
        end
        default: begin
          src_idle_pct  = 26;
          snk_stall_pct = 26;
        end
      endcase

      repeat (PHASE_FRAMES) send_frame(rand_frame());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
